// ----- rtl/core/epvo_pkg.sv -----
// types and constants shared by the encoder position and velocity observer
`timescale 1ns / 1ps

package epvo_pkg;

   localparam int unsigned MS_PER_SECOND = 1000;

   typedef enum logic {
      OP_INIT   = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] enc_count;
   } req_type;

   typedef struct packed {
      logic signed [15:0] delta_counts;
      logic signed [31:0] position;
      logic signed [31:0] fast_velocity;
      logic signed [31:0] slow_velocity;
      logic               fast_valid;
      logic               slow_valid;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic               do_fast;
      logic               do_slow;
      logic signed [15:0] delta;
      logic signed [31:0] pos;
   } stage_type;

endpackage

// ----- rtl/core/encoder_position_velocity_observer_unit.sv -----
// encoder position and velocity observer top level with position history memory
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   epvo_pkg::req_type
//   rsp_      out         rsp_valid / rsp_ready   epvo_pkg::rsp_type
//
// one request per cycle sustained while the output is not stalled; a request passes s1, s2, s3 and the output register
// before its result is offered; position, index and sample count update in the accept cycle, which also writes the
// history memory and issues both window reads on its two read ports
// then difference, constant scale multiply, and velocity update with output register
// reset clears control state and velocities; the history needs no clearing pass
// a stalled output fills the stages behind it before req_ready drops
`timescale 1ns / 1ps

module encoder_position_velocity_observer_unit #(
   parameter int HISTORY_DEPTH = 128,
   parameter int FAST_WINDOW   = 10,
   parameter int SLOW_WINDOW   = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  epvo_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output epvo_pkg::rsp_type rsp_payload
);

   import epvo_pkg::*;

   localparam int IDX_W       = $clog2(HISTORY_DEPTH);
   localparam int COUNT_LIMIT = (FAST_WINDOW > SLOW_WINDOW) ? FAST_WINDOW : SLOW_WINDOW;
   localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);
   localparam int FAST_BACK   = FAST_WINDOW % HISTORY_DEPTH;
   localparam int SLOW_BACK   = SLOW_WINDOW % HISTORY_DEPTH;
   localparam logic [IDX_W:0] DEPTH_X     = (IDX_W + 1)'(HISTORY_DEPTH);
   localparam logic [IDX_W:0] FAST_OFFSET = (IDX_W + 1)'(HISTORY_DEPTH - FAST_BACK);
   localparam logic [IDX_W:0] SLOW_OFFSET = (IDX_W + 1)'(HISTORY_DEPTH - SLOW_BACK);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_LIMIT);
   localparam logic [CNT_W-1:0] CNT_FAST  = CNT_W'(FAST_WINDOW);
   localparam logic [CNT_W-1:0] CNT_SLOW  = CNT_W'(SLOW_WINDOW);
   localparam logic [31:0] FAST_SCALE = 32'(MS_PER_SECOND / FAST_WINDOW);
   localparam logic [31:0] SLOW_SCALE = 32'(MS_PER_SECOND / SLOW_WINDOW);

   logic [31:0] hist_mem [HISTORY_DEPTH];

   logic [15:0]      last_raw_ff, last_raw_in;
   logic [31:0]      pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   stage_type        s1_ff, s1_in, s2_ff, s3_ff;
   logic [31:0]      rd_fast_ff, rd_slow_ff;
   logic [31:0]      diff_fast_ff, diff_slow_ff, diff_fast_in, diff_slow_in;
   logic [31:0]      prod_fast_ff, prod_slow_ff;
   logic [31:0]      fast_speed_ff, fast_speed_in, slow_speed_ff, slow_speed_in;
   logic [1:0]       flags_ff, flags_in;
   rsp_type          rsp_ff, rsp_in;

   logic             req_fire, mv1, mv2, mv3, out_free;
   logic [15:0]      delta;
   logic [31:0]      pos_upd;
   logic [IDX_W-1:0] idx_next, fast_addr, slow_addr, wr_addr;
   logic [IDX_W:0]   fast_sum, slow_sum;
   logic [CNT_W-1:0] cnt_next;
   logic [31:0]      wr_data;

   // pipeline flow
   assign out_free  = !out_v_ff || rsp_ready;
   assign mv3       = s3_v_ff && out_free;
   assign mv2       = s2_v_ff && (!s3_v_ff || mv3);
   assign mv1       = s1_v_ff && (!s2_v_ff || mv2);
   assign req_ready = !s1_v_ff || mv1;
   assign req_fire  = req_valid && req_ready;

   // accept stage: position, index, count
   always_comb begin
      delta    = req_payload.enc_count - last_raw_ff;
      pos_upd  = pos_ff + {{16{delta[15]}}, delta};
      idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      cnt_next = (cnt_ff < CNT_LIMIT) ? cnt_ff + 1'b1 : cnt_ff;
      fast_sum = {1'b0, idx_next} + FAST_OFFSET;
      slow_sum = {1'b0, idx_next} + SLOW_OFFSET;
      fast_addr = (fast_sum >= DEPTH_X) ? IDX_W'(fast_sum - DEPTH_X) : IDX_W'(fast_sum);
      slow_addr = (slow_sum >= DEPTH_X) ? IDX_W'(slow_sum - DEPTH_X) : IDX_W'(slow_sum);

      last_raw_in = req_payload.enc_count;
      s1_in.op    = req_payload.op;
      unique case (req_payload.op)
         OP_INIT: begin
            pos_in        = '0;
            idx_in        = '0;
            cnt_in        = '0;
            wr_addr       = '0;
            wr_data       = '0;
            s1_in.do_fast = 1'b0;
            s1_in.do_slow = 1'b0;
            s1_in.delta   = '0;
            s1_in.pos     = '0;
         end
         OP_UPDATE: begin
            pos_in        = pos_upd;
            idx_in        = idx_next;
            cnt_in        = cnt_next;
            wr_addr       = idx_next;
            wr_data       = pos_upd;
            s1_in.do_fast = (cnt_next >= CNT_FAST);
            s1_in.do_slow = (cnt_next >= CNT_SLOW);
            s1_in.delta   = delta;
            s1_in.pos     = pos_upd;
         end
         default: begin
            pos_in        = pos_ff;
            idx_in        = idx_ff;
            cnt_in        = cnt_ff;
            wr_addr       = '0;
            wr_data       = '0;
            s1_in.do_fast = 1'b0;
            s1_in.do_slow = 1'b0;
            s1_in.delta   = '0;
            s1_in.pos     = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= '0;
         pos_ff      <= '0;
         idx_ff      <= '0;
         cnt_ff      <= '0;
      end else if (req_fire) begin
         last_raw_ff <= last_raw_in;
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
      end
   end

   // history memory: one write, two reads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hist_mem[wr_addr] <= wr_data;
         rd_fast_ff        <= hist_mem[fast_addr];
         rd_slow_ff        <= hist_mem[slow_addr];
      end
   end

   // a window that is a multiple of the depth addresses the slot being written; its difference is forced to zero
   assign diff_fast_in = (FAST_BACK == 0) ? '0 : s1_ff.pos - rd_fast_ff;
   assign diff_slow_in = (SLOW_BACK == 0) ? '0 : s1_ff.pos - rd_slow_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (mv1) begin
         s2_ff        <= s1_ff;
         diff_fast_ff <= diff_fast_in;
         diff_slow_ff <= diff_slow_in;
      end
      if (mv2) begin
         s3_ff        <= s2_ff;
         prod_fast_ff <= diff_fast_ff * FAST_SCALE;
         prod_slow_ff <= diff_slow_ff * SLOW_SCALE;
      end
      if (mv3) begin
         rsp_ff <= rsp_in;
      end
   end

   // velocity update and result
   always_comb begin
      fast_speed_in = fast_speed_ff;
      slow_speed_in = slow_speed_ff;
      flags_in      = flags_ff;
      priority if (s3_ff.op == OP_INIT) begin
         fast_speed_in = '0;
         slow_speed_in = '0;
         flags_in      = '0;
      end else begin
         if (s3_ff.do_fast) begin
            fast_speed_in = prod_fast_ff;
            flags_in[0]   = 1'b1;
         end
         if (s3_ff.do_slow) begin
            slow_speed_in = prod_slow_ff;
            flags_in[1]   = 1'b1;
         end
      end
      rsp_in.delta_counts  = s3_ff.delta;
      rsp_in.position      = s3_ff.pos;
      rsp_in.fast_velocity = fast_speed_in;
      rsp_in.slow_velocity = slow_speed_in;
      rsp_in.fast_valid    = flags_in[0];
      rsp_in.slow_valid    = flags_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
         fast_speed_ff <= '0;
         slow_speed_ff <= '0;
         flags_ff      <= '0;
      end else begin
         if (req_fire || mv1) begin
            s1_v_ff <= req_fire;
         end
         if (mv1 || mv2) begin
            s2_v_ff <= mv1;
         end
         if (mv2 || mv3) begin
            s3_v_ff <= mv2;
         end
         if (mv3 || out_free) begin
            out_v_ff <= mv3;
         end
         if (mv3) begin
            fast_speed_ff <= fast_speed_in;
            slow_speed_ff <= slow_speed_in;
            flags_ff      <= flags_in;
         end
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LIMIT) else $error("sample count above limit");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX) else $error("history index out of range");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.op == OP_INIT |=> idx_ff == '0 && cnt_ff == '0 && pos_ff == '0)
      else $error("init did not clear state");

   a_fire_fills: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_v_ff) else $error("accepted request lost");

   a_flag_order: assert property (@(posedge clock) disable iff (reset)
      (FAST_WINDOW <= SLOW_WINDOW) && flags_ff[1] |-> flags_ff[0])
      else $error("slow window valid before fast window");

endmodule
